>>> hdl/dshs_pkg.sv
// Package for the drive source handover supervisor.
// Holds the item structs, mode encoding, request codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package dshs_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CFG_WIDTH       = 16;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET_VAL = 16'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CR_ENGAGE_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PL_ENGAGE_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ES_CONFIRM_LIMIT = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CR_RELEASE_TICKS = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PL_RELEASE_TICKS = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ES_RELEASE_TICKS = 3'd5;

  // operator select
  localparam logic [1:0] SEL_NONE    = 2'd0;
  localparam logic [1:0] SEL_JOY     = 2'd1;
  localparam logic [1:0] SEL_CRUISE  = 2'd2;
  localparam logic [1:0] SEL_PLANNER = 2'd3;

  // engage requests
  localparam logic [1:0] REQ_NONE      = 2'd0;
  localparam logic [1:0] REQ_ENGAGE    = 2'd1;
  localparam logic [1:0] REQ_DISENGAGE = 2'd2;

  // base estop command
  localparam logic [1:0] ES_NONE  = 2'd0;
  localparam logic [1:0] ES_SET   = 2'd1;
  localparam logic [1:0] ES_RESET = 2'd2;

  // controller status
  localparam logic [1:0] ST_JOY    = 2'd0;
  localparam logic [1:0] ST_CR     = 2'd1;
  localparam logic [1:0] ST_PL     = 2'd2;
  localparam logic [1:0] ST_ESTOP  = 2'd3;

  // valid_bits positions
  localparam int unsigned VB_JOY     = 0;
  localparam int unsigned VB_CRUISE  = 1;
  localparam int unsigned VB_PLANNER = 2;
  localparam int unsigned VB_ESTOP   = 3;

  typedef enum logic [3:0] {
    MODE_JOY       = 4'd0,
    MODE_JOY2CR    = 4'd1,
    MODE_CR        = 4'd2,
    MODE_CR2JOY    = 4'd3,
    MODE_JOY2PL    = 4'd4,
    MODE_PL        = 4'd5,
    MODE_PL2JOY    = 4'd6,
    MODE_2ESTOP    = 4'd7,
    MODE_ESTOP     = 4'd8,
    MODE_ESTOP2JOY = 4'd9
  } mode_t;

  typedef struct packed {
    logic [63:0] joy_command;
    logic [63:0] cruise_command;
    logic [63:0] planner_command;
    logic [3:0]  valid_bits;
    logic        teleop_estop_set;
    logic        monitor_estop_set;
    logic [1:0]  operator_select;
    logic        override_active;
    logic        cruise_engaged;
    logic        planner_engaged;
    logic        base_in_estop;
  } in_item_t;

  typedef struct packed {
    logic [63:0] drive_command;
    logic        drive_valid;
    logic [1:0]  base_estop_out;
    logic        base_estop_valid;
    logic [1:0]  cruise_request;
    logic [1:0]  planner_request;
    logic [1:0]  source_status;
  } out_item_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] cr_engage_limit;
    logic [CFG_WIDTH-1:0] pl_engage_limit;
    logic [CFG_WIDTH-1:0] es_confirm_limit;
    logic [CFG_WIDTH-1:0] cr_release_ticks;
    logic [CFG_WIDTH-1:0] pl_release_ticks;
    logic [CFG_WIDTH-1:0] es_release_ticks;
  } cfg_regs_t;

endpackage

>>> hdl/dshs_ctrl.sv
// Per-tick mode update of the handover supervisor: next mode, wait counters
// and the result item. Pure combinational logic. Depends on dshs_pkg.
`timescale 1ns / 1ps

module dshs_ctrl #(
  parameter int unsigned COUNT_WIDTH = dshs_pkg::COUNT_WIDTH_DEF
) (
  input  dshs_pkg::in_item_t        item,
  input  dshs_pkg::cfg_regs_t       cfg,
  input  dshs_pkg::mode_t           mode,
  input  logic [COUNT_WIDTH-1:0]    cr_eng_cnt,
  input  logic [COUNT_WIDTH-1:0]    pl_eng_cnt,
  input  logic [COUNT_WIDTH-1:0]    es_cnf_cnt,
  input  logic [COUNT_WIDTH-1:0]    cr_rel_cnt,
  input  logic [COUNT_WIDTH-1:0]    pl_rel_cnt,
  input  logic [COUNT_WIDTH-1:0]    es_rel_cnt,
  output dshs_pkg::mode_t           mode_nxt,
  output logic [COUNT_WIDTH-1:0]    cr_eng_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]    pl_eng_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]    es_cnf_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]    cr_rel_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]    pl_rel_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]    es_rel_cnt_nxt,
  output dshs_pkg::out_item_t       result
);
  import dshs_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  // limit reached, or counter saturated
  function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
                                   input logic [CFG_WIDTH-1:0] lim);
    logic [CMP_W-1:0] c_ext;
    logic [CMP_W-1:0] l_ext;
    c_ext = CMP_W'(cnt);
    l_ext = CMP_W'(lim);
    return (c_ext >= l_ext) || (&cnt);
  endfunction

  logic back;
  assign back = (item.operator_select == SEL_JOY) || item.override_active;

  always_comb begin
    mode_nxt       = mode;
    cr_eng_cnt_nxt = cr_eng_cnt;
    pl_eng_cnt_nxt = pl_eng_cnt;
    es_cnf_cnt_nxt = es_cnf_cnt;
    cr_rel_cnt_nxt = cr_rel_cnt;
    pl_rel_cnt_nxt = pl_rel_cnt;
    es_rel_cnt_nxt = es_rel_cnt;

    result.drive_command     = item.joy_command;
    result.drive_valid       = item.valid_bits[VB_JOY];
    result.base_estop_out    = ES_NONE;
    result.base_estop_valid  = item.valid_bits[VB_ESTOP];
    result.cruise_request    = REQ_NONE;
    result.planner_request   = REQ_NONE;
    result.source_status     = ST_JOY;

    unique case (mode)
      MODE_JOY: begin
        priority if (item.teleop_estop_set) begin
          mode_nxt = MODE_2ESTOP;
          result.base_estop_out = ES_SET;
        end else if (item.operator_select == SEL_CRUISE) begin
          mode_nxt = MODE_JOY2CR;
          result.cruise_request = REQ_ENGAGE;
        end else if (item.operator_select == SEL_PLANNER) begin
          mode_nxt = MODE_JOY2PL;
          result.planner_request = REQ_ENGAGE;
        end else begin
          mode_nxt = MODE_JOY;
        end
      end
      MODE_JOY2CR: begin
        priority if (item.cruise_engaged) begin
          mode_nxt = MODE_CR;
          result.drive_command     = item.cruise_command;
          result.drive_valid       = item.valid_bits[VB_CRUISE];
          result.source_status     = ST_CR;
          cr_eng_cnt_nxt = '0;
        end else if (reached(cr_eng_cnt, cfg.cr_engage_limit)) begin
          mode_nxt = MODE_CR2JOY;
          cr_eng_cnt_nxt = '0;
          result.cruise_request = REQ_DISENGAGE;
        end else begin
          cr_eng_cnt_nxt = cr_eng_cnt + CNT_ONE;
          result.cruise_request = REQ_ENGAGE;
        end
      end
      MODE_CR: begin
        priority if (back) begin
          mode_nxt = MODE_CR2JOY;
          result.cruise_request = REQ_DISENGAGE;
        end else if (item.teleop_estop_set) begin
          mode_nxt = MODE_2ESTOP;
          result.base_estop_out = ES_SET;
          result.cruise_request = REQ_DISENGAGE;
        end else begin
          result.drive_command     = item.cruise_command;
          result.drive_valid       = item.valid_bits[VB_CRUISE];
          result.source_status     = ST_CR;
        end
      end
      MODE_CR2JOY: begin
        if (reached(cr_rel_cnt, cfg.cr_release_ticks)) begin
          mode_nxt = MODE_JOY;
          cr_rel_cnt_nxt = '0;
        end else begin
          cr_rel_cnt_nxt = cr_rel_cnt + CNT_ONE;
          result.cruise_request = REQ_DISENGAGE;
        end
      end
      MODE_JOY2PL: begin
        priority if (item.planner_engaged) begin
          mode_nxt = MODE_PL;
          result.drive_command     = item.planner_command;
          result.drive_valid       = item.valid_bits[VB_PLANNER];
          result.source_status     = ST_PL;
          pl_eng_cnt_nxt = '0;
        end else if (reached(pl_eng_cnt, cfg.pl_engage_limit)) begin
          mode_nxt = MODE_PL2JOY;
          pl_eng_cnt_nxt = '0;
          result.planner_request = REQ_DISENGAGE;
        end else begin
          pl_eng_cnt_nxt = pl_eng_cnt + CNT_ONE;
          result.planner_request = REQ_ENGAGE;
        end
      end
      MODE_PL: begin
        priority if (back) begin
          mode_nxt = MODE_PL2JOY;
          result.planner_request = REQ_DISENGAGE;
        end else if (item.teleop_estop_set || item.monitor_estop_set) begin
          mode_nxt = MODE_2ESTOP;
          result.base_estop_out  = ES_SET;
          result.planner_request = REQ_DISENGAGE;
        end else begin
          result.drive_command     = item.planner_command;
          result.drive_valid       = item.valid_bits[VB_PLANNER];
          result.source_status     = ST_PL;
        end
      end
      MODE_PL2JOY: begin
        if (reached(pl_rel_cnt, cfg.pl_release_ticks)) begin
          mode_nxt = MODE_JOY;
          pl_rel_cnt_nxt = '0;
        end else begin
          pl_rel_cnt_nxt = pl_rel_cnt + CNT_ONE;
          result.planner_request = REQ_DISENGAGE;
        end
      end
      MODE_2ESTOP: begin
        priority if (item.base_in_estop) begin
          mode_nxt = MODE_ESTOP;
          result.source_status = ST_ESTOP;
          es_cnf_cnt_nxt = '0;
        end else if (reached(es_cnf_cnt, cfg.es_confirm_limit)) begin
          mode_nxt = MODE_ESTOP2JOY;
          es_cnf_cnt_nxt = '0;
          result.base_estop_out = ES_RESET;
        end else begin
          es_cnf_cnt_nxt = es_cnf_cnt + CNT_ONE;
          result.base_estop_out  = ES_SET;
          result.planner_request = REQ_DISENGAGE;
          result.cruise_request  = REQ_DISENGAGE;
        end
      end
      MODE_ESTOP: begin
        if (back) begin
          mode_nxt = MODE_ESTOP2JOY;
          result.base_estop_out = ES_RESET;
        end else begin
          result.source_status = ST_ESTOP;
        end
      end
      MODE_ESTOP2JOY: begin
        if (reached(es_rel_cnt, cfg.es_release_ticks)) begin
          mode_nxt = MODE_JOY;
          es_rel_cnt_nxt = '0;
        end else begin
          es_rel_cnt_nxt = es_rel_cnt + CNT_ONE;
          result.base_estop_out = ES_RESET;
        end
      end
      default: begin
        // unused mode codes: defaults, state held
        mode_nxt = mode;
      end
    endcase
  end

endmodule

>>> hdl/drive_source_handover_supervisor_top.sv
// Top level of the drive source handover supervisor: input register,
// configuration registers, state registers and result register.
// Depends on dshs_pkg and dshs_ctrl.
`timescale 1ns / 1ps

// The supervisor takes one item per control tick and returns exactly one
// result item for it. Each item is captured in an input register, where the
// mode update (dshs_ctrl) works on it; its result is loaded into the result
// register once that register is free, so a new item can be accepted on
// every cycle. One item per cycle is sustained as long as the result side
// does not stall; a stall on out_stall holds the result, and an item held
// in the input register raises in_stall. The mode register and
// the six wait counters change only when an item passes into the result
// register. Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect
// on the next edge; indexes above five are ignored. All limits reset to 100.
module drive_source_handover_supervisor_top #(
  parameter int unsigned COUNT_WIDTH = dshs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  dshs_pkg::in_item_t                     in_data,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output dshs_pkg::out_item_t                    out_data,
  // configuration
  input  logic                                   cfg_we,
  input  logic [dshs_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [dshs_pkg::CFG_WIDTH-1:0]         cfg_wdata
);
  import dshs_pkg::*;

  // input stage
  in_item_t  in_r;
  logic      in_valid_r;
  logic      in_valid_nxt;
  // result stage
  out_item_t out_r;
  logic      out_valid_r;
  // configuration
  cfg_regs_t cfg_r;
  // mode and wait counters
  mode_t                  mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] cr_eng_cnt_r, cr_eng_cnt_nxt;
  logic [COUNT_WIDTH-1:0] pl_eng_cnt_r, pl_eng_cnt_nxt;
  logic [COUNT_WIDTH-1:0] es_cnf_cnt_r, es_cnf_cnt_nxt;
  logic [COUNT_WIDTH-1:0] cr_rel_cnt_r, cr_rel_cnt_nxt;
  logic [COUNT_WIDTH-1:0] pl_rel_cnt_r, pl_rel_cnt_nxt;
  logic [COUNT_WIDTH-1:0] es_rel_cnt_r, es_rel_cnt_nxt;
  out_item_t              result;

  logic out_free;   // result register can take a new item
  logic advance;    // held item moves into the result register
  logic in_accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    priority if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cr_engage_limit  <= CFG_RESET_VAL;
      cfg_r.pl_engage_limit  <= CFG_RESET_VAL;
      cfg_r.es_confirm_limit <= CFG_RESET_VAL;
      cfg_r.cr_release_ticks <= CFG_RESET_VAL;
      cfg_r.pl_release_ticks <= CFG_RESET_VAL;
      cfg_r.es_release_ticks <= CFG_RESET_VAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CR_ENGAGE_LIMIT:  cfg_r.cr_engage_limit  <= cfg_wdata;
        CFG_PL_ENGAGE_LIMIT:  cfg_r.pl_engage_limit  <= cfg_wdata;
        CFG_ES_CONFIRM_LIMIT: cfg_r.es_confirm_limit <= cfg_wdata;
        CFG_CR_RELEASE_TICKS: cfg_r.cr_release_ticks <= cfg_wdata;
        CFG_PL_RELEASE_TICKS: cfg_r.pl_release_ticks <= cfg_wdata;
        CFG_ES_RELEASE_TICKS: cfg_r.es_release_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // per-tick mode update
  dshs_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .item           (in_r),
    .cfg            (cfg_r),
    .mode           (mode_r),
    .cr_eng_cnt     (cr_eng_cnt_r),
    .pl_eng_cnt     (pl_eng_cnt_r),
    .es_cnf_cnt     (es_cnf_cnt_r),
    .cr_rel_cnt     (cr_rel_cnt_r),
    .pl_rel_cnt     (pl_rel_cnt_r),
    .es_rel_cnt     (es_rel_cnt_r),
    .mode_nxt       (mode_nxt),
    .cr_eng_cnt_nxt (cr_eng_cnt_nxt),
    .pl_eng_cnt_nxt (pl_eng_cnt_nxt),
    .es_cnf_cnt_nxt (es_cnf_cnt_nxt),
    .cr_rel_cnt_nxt (cr_rel_cnt_nxt),
    .pl_rel_cnt_nxt (pl_rel_cnt_nxt),
    .es_rel_cnt_nxt (es_rel_cnt_nxt),
    .result         (result)
  );

  // state commits only as the item leaves for the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_JOY;
      cr_eng_cnt_r <= '0;
      pl_eng_cnt_r <= '0;
      es_cnf_cnt_r <= '0;
      cr_rel_cnt_r <= '0;
      pl_rel_cnt_r <= '0;
      es_rel_cnt_r <= '0;
    end else if (advance) begin
      mode_r       <= mode_nxt;
      cr_eng_cnt_r <= cr_eng_cnt_nxt;
      pl_eng_cnt_r <= pl_eng_cnt_nxt;
      es_cnf_cnt_r <= es_cnf_cnt_nxt;
      cr_rel_cnt_r <= cr_rel_cnt_nxt;
      pl_rel_cnt_r <= pl_rel_cnt_nxt;
      es_rel_cnt_r <= es_rel_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a held item always reaches the result register when there is room
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("item lost between input and result register");

  // engage wait counter only runs while waiting for cruise engage
  a_cr_cnt_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (cr_eng_cnt_r != '0) |-> (mode_r == MODE_JOY2CR))
    else $error("cruise engage counter live outside its wait state");

  // estop release counter only runs while releasing estop
  a_es_rel_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (es_rel_cnt_r != '0) |-> (mode_r == MODE_ESTOP2JOY))
    else $error("estop release counter live outside its wait state");

  // while cruise drives, no cruise request is sent
  a_cr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.source_status == ST_CR) |->
      (out_r.cruise_request == REQ_NONE))
    else $error("cruise request while cruise in control");

endmodule

>>> test/dshs_handover_checker.sv
// Result checker for the drive source handover supervisor: mirrors the limit
// registers, mode and wait counters, predicts each result item and compares.
// Depends on dshs_pkg.
`timescale 1ns / 1ps

module dshs_handover_checker #(
  parameter int unsigned COUNT_WIDTH = dshs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  dshs_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  dshs_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [dshs_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [dshs_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  output int                                  fails,
  output int                                  pending
);
  import dshs_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef logic [COUNT_WIDTH-1:0] tick_cnt_t;

  cfg_regs_t  lims;
  mode_t      mode;
  tick_cnt_t  cr_engage_cnt, pl_engage_cnt, es_confirm_cnt;
  tick_cnt_t  cr_release_cnt, pl_release_cnt, es_release_cnt;
  out_item_t  drive_results_q[$];

  // a saturated counter counts as having reached any limit
  function automatic bit limit_hit(input tick_cnt_t cnt, input logic [CFG_WIDTH-1:0] lim);
    return (longint'(cnt) >= longint'(lim)) || (&cnt);
  endfunction

  // one control tick: updates mode and counters, returns the result item
  task automatic supervise_tick(input in_item_t it, output out_item_t res);
    logic go_back;
    go_back = (it.operator_select == SEL_JOY) || it.override_active;
    res.drive_command     = it.joy_command;
    res.drive_valid       = it.valid_bits[VB_JOY];
    res.base_estop_out    = ES_NONE;
    res.base_estop_valid  = it.valid_bits[VB_ESTOP];
    res.cruise_request    = REQ_NONE;
    res.planner_request   = REQ_NONE;
    res.source_status     = ST_JOY;
    case (mode)
      MODE_JOY: begin
        if (it.teleop_estop_set) begin
          mode = MODE_2ESTOP;
          res.base_estop_out = ES_SET;
        end else if (it.operator_select == SEL_CRUISE) begin
          mode = MODE_JOY2CR;
          res.cruise_request = REQ_ENGAGE;
        end else if (it.operator_select == SEL_PLANNER) begin
          mode = MODE_JOY2PL;
          res.planner_request = REQ_ENGAGE;
        end
      end
      MODE_JOY2CR: begin
        if (it.cruise_engaged) begin
          mode = MODE_CR;
          res.drive_command     = it.cruise_command;
          res.drive_valid       = it.valid_bits[VB_CRUISE];
          res.source_status     = ST_CR;
          cr_engage_cnt = '0;
        end else if (limit_hit(cr_engage_cnt, lims.cr_engage_limit)) begin
          mode = MODE_CR2JOY;
          cr_engage_cnt = '0;
          res.cruise_request = REQ_DISENGAGE;
        end else begin
          cr_engage_cnt = cr_engage_cnt + tick_cnt_t'(1);
          res.cruise_request = REQ_ENGAGE;
        end
      end
      MODE_CR: begin
        if (go_back) begin
          mode = MODE_CR2JOY;
          res.cruise_request = REQ_DISENGAGE;
        end else if (it.teleop_estop_set) begin
          mode = MODE_2ESTOP;
          res.base_estop_out = ES_SET;
          res.cruise_request = REQ_DISENGAGE;
        end else begin
          res.drive_command     = it.cruise_command;
          res.drive_valid       = it.valid_bits[VB_CRUISE];
          res.source_status     = ST_CR;
        end
      end
      MODE_CR2JOY: begin
        if (limit_hit(cr_release_cnt, lims.cr_release_ticks)) begin
          mode = MODE_JOY;
          cr_release_cnt = '0;
        end else begin
          cr_release_cnt = cr_release_cnt + tick_cnt_t'(1);
          res.cruise_request = REQ_DISENGAGE;
        end
      end
      MODE_JOY2PL: begin
        if (it.planner_engaged) begin
          mode = MODE_PL;
          res.drive_command     = it.planner_command;
          res.drive_valid       = it.valid_bits[VB_PLANNER];
          res.source_status     = ST_PL;
          pl_engage_cnt = '0;
        end else if (limit_hit(pl_engage_cnt, lims.pl_engage_limit)) begin
          mode = MODE_PL2JOY;
          pl_engage_cnt = '0;
          res.planner_request = REQ_DISENGAGE;
        end else begin
          pl_engage_cnt = pl_engage_cnt + tick_cnt_t'(1);
          res.planner_request = REQ_ENGAGE;
        end
      end
      MODE_PL: begin
        if (go_back) begin
          mode = MODE_PL2JOY;
          res.planner_request = REQ_DISENGAGE;
        end else if (it.teleop_estop_set || it.monitor_estop_set) begin
          mode = MODE_2ESTOP;
          res.base_estop_out  = ES_SET;
          res.planner_request = REQ_DISENGAGE;
        end else begin
          res.drive_command     = it.planner_command;
          res.drive_valid       = it.valid_bits[VB_PLANNER];
          res.source_status     = ST_PL;
        end
      end
      MODE_PL2JOY: begin
        if (limit_hit(pl_release_cnt, lims.pl_release_ticks)) begin
          mode = MODE_JOY;
          pl_release_cnt = '0;
        end else begin
          pl_release_cnt = pl_release_cnt + tick_cnt_t'(1);
          res.planner_request = REQ_DISENGAGE;
        end
      end
      MODE_2ESTOP: begin
        if (it.base_in_estop) begin
          mode = MODE_ESTOP;
          res.source_status = ST_ESTOP;
          es_confirm_cnt = '0;
        end else if (limit_hit(es_confirm_cnt, lims.es_confirm_limit)) begin
          mode = MODE_ESTOP2JOY;
          es_confirm_cnt = '0;
          res.base_estop_out = ES_RESET;
        end else begin
          es_confirm_cnt = es_confirm_cnt + tick_cnt_t'(1);
          res.base_estop_out  = ES_SET;
          res.cruise_request  = REQ_DISENGAGE;
          res.planner_request = REQ_DISENGAGE;
        end
      end
      MODE_ESTOP: begin
        if (go_back) begin
          mode = MODE_ESTOP2JOY;
          res.base_estop_out = ES_RESET;
        end else begin
          res.source_status = ST_ESTOP;
        end
      end
      MODE_ESTOP2JOY: begin
        if (limit_hit(es_release_cnt, lims.es_release_ticks)) begin
          mode = MODE_JOY;
          es_release_cnt = '0;
        end else begin
          es_release_cnt = es_release_cnt + tick_cnt_t'(1);
          res.base_estop_out = ES_RESET;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fails          = 0;
      lims           = {6{CFG_RESET_VAL}};
      mode           = MODE_JOY;
      cr_engage_cnt  = '0;
      pl_engage_cnt  = '0;
      es_confirm_cnt = '0;
      cr_release_cnt = '0;
      pl_release_cnt = '0;
      es_release_cnt = '0;
      drive_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CR_ENGAGE_LIMIT:  lims.cr_engage_limit  = cfg_wdata;
          CFG_PL_ENGAGE_LIMIT:  lims.pl_engage_limit  = cfg_wdata;
          CFG_ES_CONFIRM_LIMIT: lims.es_confirm_limit = cfg_wdata;
          CFG_CR_RELEASE_TICKS: lims.cr_release_ticks = cfg_wdata;
          CFG_PL_RELEASE_TICKS: lims.pl_release_ticks = cfg_wdata;
          CFG_ES_RELEASE_TICKS: lims.es_release_ticks = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_results_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result item with none expected: %h", $time, out_data);
        end else begin
          want = drive_results_q.pop_front();
          if (out_data !== want) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("%0t: result mismatch (expected / actual)", $time);
              $display("  drive_command %h / %h, drive_valid %b / %b",
                       want.drive_command, out_data.drive_command,
                       want.drive_valid, out_data.drive_valid);
              $display("  base_estop_out %0d / %0d, base_estop_valid %b / %b",
                       want.base_estop_out, out_data.base_estop_out,
                       want.base_estop_valid, out_data.base_estop_valid);
              $display("  cruise_req %0d / %0d, planner_req %0d / %0d, status %0d / %0d",
                       want.cruise_request, out_data.cruise_request,
                       want.planner_request, out_data.planner_request,
                       want.source_status, out_data.source_status);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        supervise_tick(in_data, want);
        drive_results_q.push_back(want);
      end
    end
    pending = drive_results_q.size();
  end

endmodule

>>> test/tb_drive_source_handover_supervisor_top.sv
// Testbench top for the drive source handover supervisor: clock, reset,
// stimulus, limit programming and verdict.
// Depends on dshs_pkg, drive_source_handover_supervisor_top, dshs_handover_checker.
`timescale 1ns / 1ps

module tb_drive_source_handover_supervisor_top;
  import dshs_pkg::*;

  localparam int unsigned CW          = COUNT_WIDTH_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  // margin after the last outstanding result is back
  localparam int          DRAIN_TICKS = 4;
  // indexes with no register behind them, must be ignored
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

  // limit settings used per phase; ONES is for the directed part only
  typedef enum int {
    PLAN_ONES, PLAN_RESET_VALUES, PLAN_ZERO, PLAN_FULL, PLAN_TINY,
    PLAN_SLOW_ENGAGE, PLAN_SHORT, PLAN_MID
  } limit_plan_t;

  typedef enum int { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE } stall_style_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_WIDTH-1:0]      cfg_wdata;

  int fails;
  int pending;
  int cycles = 0;
  int burst_left;

  stall_style_t stall_style = STALL_NONE;
  int           stall_span  = 0;

  drive_source_handover_supervisor_top #(
    .COUNT_WIDTH (CW)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // watches both channels and the register port, predicts and compares
  dshs_handover_checker #(
    .COUNT_WIDTH (CW)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure: a style is held for a random span, so there
  // are long clean stretches as well as heavy and toggling stalls.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_style = stall_style_t'($urandom_range(STALL_NONE, STALL_TOGGLE));
      stall_span  = $urandom_range(10, 150);
    end
    stall_span--;
    case (stall_style)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 7) != 0);
      default:     out_stall = ~out_stall;
    endcase
  end

  // all register writes happen at the falling edge
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [CFG_WIDTH-1:0] plan_limit(input limit_plan_t plan,
                                                      input bit is_release);
    case (plan)
      PLAN_ONES:         return CFG_WIDTH'(1);
      PLAN_RESET_VALUES: return CFG_RESET_VAL;
      PLAN_ZERO:         return '0;
      PLAN_FULL:         return '1;
      PLAN_TINY:         return CFG_WIDTH'($urandom_range(1, 6));
      // engage and confirm waits at full scale, quick releases
      PLAN_SLOW_ENGAGE:  return is_release ? CFG_WIDTH'($urandom_range(0, 3)) : '1;
      PLAN_SHORT:        return CFG_WIDTH'($urandom_range(0, 20));
      default:           return CFG_WIDTH'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic int plan_items(input limit_plan_t plan);
    case (plan)
      PLAN_RESET_VALUES: return 250;
      PLAN_FULL:         return 150;
      PLAN_MID:          return 325;
      default:           return 300;
    endcase
  endfunction

  task automatic load_plan(input limit_plan_t plan);
    write_reg(CFG_CR_ENGAGE_LIMIT,  plan_limit(plan, 1'b0));
    write_reg(CFG_PL_ENGAGE_LIMIT,  plan_limit(plan, 1'b0));
    write_reg(CFG_ES_CONFIRM_LIMIT, plan_limit(plan, 1'b0));
    write_reg(CFG_CR_RELEASE_TICKS, plan_limit(plan, 1'b1));
    write_reg(CFG_PL_RELEASE_TICKS, plan_limit(plan, 1'b1));
    write_reg(CFG_ES_RELEASE_TICKS, plan_limit(plan, 1'b1));
  endtask

  // valid low, then wait for every outstanding result plus a margin
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_TICKS) @(negedge clk);
  endtask

  // Random words and valid bits, handshake fields as given
  function automatic in_item_t shaped_tick(input logic [1:0] sel, input logic ovr,
                                           input logic tes, input logic mes,
                                           input logic ce, input logic pe,
                                           input logic be);
    in_item_t it;
    it.joy_command       = {$urandom, $urandom};
    it.cruise_command    = {$urandom, $urandom};
    it.planner_command   = {$urandom, $urandom};
    it.valid_bits        = 4'($urandom_range(0, 15));
    it.operator_select   = sel;
    it.override_active   = ovr;
    it.teleop_estop_set  = tes;
    it.monitor_estop_set = mes;
    it.cruise_engaged    = ce;
    it.planner_engaged   = pe;
    it.base_in_estop     = be;
    return it;
  endfunction

  // Mostly plausible traffic: selects and statuses weighted so that
  // handovers complete and modes are held for a while. One item in
  // eight is plain noise with every field uniform.
  function automatic in_item_t random_tick();
    bit          noisy;
    int unsigned pick;
    logic [1:0]  sel;
    noisy = ($urandom_range(0, 7) == 0);
    pick  = $urandom_range(0, 15);
    if (noisy)
      sel = 2'($urandom_range(0, 3));
    else if (pick < 9)
      sel = SEL_NONE;
    else if (pick < 11)
      sel = SEL_JOY;
    else if (pick < 13)
      sel = SEL_CRUISE;
    else
      sel = SEL_PLANNER;
    return shaped_tick(sel,
                       noisy ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 15) == 0),
                       noisy ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 11) == 0),
                       noisy ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 7) == 0),
                       noisy ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 3) == 0),
                       noisy ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 3) == 0),
                       noisy ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 3) == 0));
  endfunction

  // Present one item at the falling edge and hold it until taken. Items
  // go out in bursts; at the end of a burst valid drops and the idle
  // payload is scrambled.
  task automatic push_tick(input in_item_t it);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      in_data  = random_tick();
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    in_item_t full_item;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    burst_left = $urandom_range(1, 40);
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed part with every limit at one, so each wait and release
    // runs out after a single extra tick. Writes to the spare indexes
    // must leave those limits alone.
    load_plan(PLAN_ONES);
    write_reg(CFG_SPARE_LO, '0);
    write_reg(CFG_SPARE_HI, '0);

    full_item                 = shaped_tick(SEL_CRUISE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    full_item.joy_command     = '1;
    full_item.cruise_command  = '1;
    full_item.planner_command = '1;
    full_item.valid_bits      = '1;

    push_tick('0);                                                   // all fields low
    push_tick(full_item);                                            // all words high, ask cruise
    push_tick(shaped_tick(SEL_PLANNER, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1)); // still waiting
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)); // cruise engaged
    push_tick(shaped_tick(SEL_PLANNER, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)); // ignored in cruise
    // joystick select beats the estop request
    push_tick(shaped_tick(SEL_JOY,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // release
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // back to joystick
    push_tick(shaped_tick(SEL_PLANNER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // ask planner
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // waiting
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // engage gives up
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_PLANNER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0)); // planner engaged
    // monitor estop is honoured in planner mode
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)); // base confirms
    // override beats a fresh estop request while in estop
    push_tick(shaped_tick(SEL_NONE,    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_CRUISE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    push_tick(shaped_tick(SEL_CRUISE,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // estop from cruise
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // no confirm yet
    push_tick(shaped_tick(SEL_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // confirm times out

    // Random phases. Each one starts from an idle block: valid low and
    // every result back before the limits are reprogrammed.
    for (int p = PLAN_RESET_VALUES; p <= PLAN_MID; p++) begin
      settle();
      load_plan(limit_plan_t'(p));
      repeat (plan_items(limit_plan_t'(p))) push_tick(random_tick());
    end

    settle();
    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> drive_source_handover_supervisor_top.f
hdl/dshs_pkg.sv
hdl/dshs_ctrl.sv
hdl/drive_source_handover_supervisor_top.sv
test/dshs_handover_checker.sv
test/tb_drive_source_handover_supervisor_top.sv
